@@ hdl/bive_pkg.sv @@
// ----------------------------------------------------------------------------
// bive_pkg
// Shared widths, request and status codes and sequencer states for the
// bounded vector engine.
// ----------------------------------------------------------------------------
package bive_pkg;

    localparam int FUNC_W      = 3;
    localparam int IDX_W       = 16;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 10;
    localparam int COUNT_OUT_W = 11;

    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_WORD_WIDTH = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 3'd0,
        FN_POP    = 3'd1,
        FN_READ   = 3'd2,
        FN_WRITE  = 3'd3,
        FN_ERASE  = 3'd4,
        FN_FIND   = 3'd5,
        FN_REMOVE = 3'd6
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCESS,
        S_FILL,
        S_SHIFT,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

@@ hdl/bive_req_if.sv @@
// ----------------------------------------------------------------------------
// bive_req_if
// Request channel: valid/ready handshake with operation, index and value.
// ----------------------------------------------------------------------------
interface bive_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [bive_pkg::FUNC_W-1:0]          func;
    logic [bive_pkg::IDX_W-1:0]           index;
    logic signed [bive_pkg::DATA_W-1:0]   value;

    modport source (output valid, output func, output index, output value, input ready);
    modport sink   (input valid, input func, input index, input value, output ready);
endinterface

@@ hdl/bive_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bive_rsp_if
// Result channel: valid/ready handshake with status, data and vector state.
// ----------------------------------------------------------------------------
interface bive_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [bive_pkg::STATUS_W-1:0]         status;
    logic signed [bive_pkg::DATA_W-1:0]    data_out;
    logic                                  found;
    logic [bive_pkg::POS_W-1:0]            position;
    logic [bive_pkg::COUNT_OUT_W-1:0]      count;
    logic                                  empty_res;

    modport source (output valid, output status, output data_out, output found,
                    output position, output count, output empty_res, input ready);
    modport sink   (input valid, input status, input data_out, input found,
                    input position, input count, input empty_res, output ready);
endinterface

@@ hdl/bive_ram.sv @@
// ----------------------------------------------------------------------------
// bive_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bive_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bounded_int_vector_engine_core.sv @@
// ----------------------------------------------------------------------------
// bounded_int_vector_engine_core
// Fixed-capacity vector of signed words with push, pop, read, write, erase,
// find and remove, driven by a small sequencer around one RAM.
// ----------------------------------------------------------------------------
// usage:
//   requests arrive on i_req (valid/ready); each transfer yields exactly one
//   result transfer on o_rsp, in order. i_req.ready is high only while the
//   sequencer is idle, so one request is in flight at a time.
// requests that walk the vector: write zero-fills the entries from the count
// up to the index; erase shifts the entries after the index down; find scans
// up to the first match or to the count; remove scans to the first match and
// shifts the entries after it down. push, pop, read, unused codes and failed
// requests do not walk. the walk is set by the single RAM port pair: at most
// one entry read and one written per cycle while walking the vector.
// reset clears the used count and the handshake state; the store itself is
// not cleared, entries below the count are always written before use.
// when the receiver stalls, the result is held in the output register; the
// next request can be taken, and its result waits until the slot drains.
// ----------------------------------------------------------------------------
module bounded_int_vector_engine_core #(
    parameter int CAPACITY   = bive_pkg::DEF_CAPACITY,
    parameter int WORD_WIDTH = bive_pkg::DEF_WORD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bive_req_if.sink    i_req,
    bive_rsp_if.source  o_rsp
);
    import bive_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_ptr, n_ptr;
    t_func                   r_func, n_func;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [WORD_WIDTH-1:0]   r_val, n_val;
    t_status                 r_pstat, n_pstat;
    logic [DATA_W-1:0]       r_pdata, n_pdata;
    logic                    r_pfound, n_pfound;
    logic [ADDR_W-1:0]       r_ppos, n_ppos;

    logic                    r_ovalid, n_ovalid;
    t_status                 r_ostat, n_ostat;
    logic [DATA_W-1:0]       r_odata, n_odata;
    logic                    r_ofound, n_ofound;
    logic [POS_W-1:0]        r_opos, n_opos;
    logic [COUNT_OUT_W-1:0]  r_ocount, n_ocount;
    logic                    r_oempty, n_oempty;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [WORD_WIDTH-1:0]   mem_wdata;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [WORD_WIDTH-1:0]   mem_rdata;

    logic                    accept;
    logic [WORD_WIDTH-1:0]   in_word;
    logic signed [WORD_WIDTH-1:0] rd_s;
    logic signed [63:0]      rd_wide;

    bive_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign in_word     = WORD_WIDTH'(i_req.value);
    assign rd_s        = mem_rdata;
    assign rd_wide     = 64'(rd_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_func   <= n_func;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_pstat  <= n_pstat;
        r_pdata  <= n_pdata;
        r_pfound <= n_pfound;
        r_ppos   <= n_ppos;
        r_ostat  <= n_ostat;
        r_odata  <= n_odata;
        r_ofound <= n_ofound;
        r_opos   <= n_opos;
        r_ocount <= n_ocount;
        r_oempty <= n_oempty;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_func    = r_func;
        n_idx     = r_idx;
        n_val     = r_val;
        n_pstat   = r_pstat;
        n_pdata   = r_pdata;
        n_pfound  = r_pfound;
        n_ppos    = r_ppos;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_ostat   = r_ostat;
        n_odata   = r_odata;
        n_ofound  = r_ofound;
        n_opos    = r_opos;
        n_ocount  = r_ocount;
        n_oempty  = r_oempty;
        mem_we    = 1'b0;
        mem_waddr = r_count[ADDR_W-1:0];
        mem_wdata = r_val;
        mem_raddr = r_ptr[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func   = t_func'(i_req.func);
                    n_idx    = i_req.index;
                    n_val    = in_word;
                    n_pstat  = ST_OK;
                    n_pdata  = '0;
                    n_pfound = 1'b0;
                    n_ppos   = '0;
                    n_state  = S_DONE;
                    case (t_func'(i_req.func))
                        FN_PUSH: begin
                            if (CMP_W'(r_count) >= CAP_C) begin
                                n_pstat = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[ADDR_W-1:0];
                                mem_wdata = in_word;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        FN_POP: begin
                            if (r_count == '0) begin
                                n_pstat = ST_EMPTY;
                            end else begin
                                n_count   = r_count - 1'b1;
                                mem_raddr = n_count[ADDR_W-1:0];
                                n_state   = S_ACCESS;
                            end
                        end
                        FN_READ: begin
                            if (CMP_W'(i_req.index) >= CMP_W'(r_count)) begin
                                n_pstat = ST_RANGE;
                            end else begin
                                mem_raddr = i_req.index[ADDR_W-1:0];
                                n_state   = S_ACCESS;
                            end
                        end
                        FN_WRITE: begin
                            if (CMP_W'(i_req.index) >= CAP_C) begin
                                n_pstat = ST_RANGE;
                            end else begin
                                n_state = S_FILL;
                            end
                        end
                        FN_ERASE: begin
                            if (CMP_W'(i_req.index) >= CMP_W'(r_count)) begin
                                n_pstat = ST_RANGE;
                            end else begin
                                n_ptr     = CNT_W'(i_req.index) + 1'b1;
                                mem_raddr = n_ptr[ADDR_W-1:0];
                                n_state   = S_SHIFT;
                            end
                        end
                        FN_FIND, FN_REMOVE: begin
                            n_ptr     = '0;
                            mem_raddr = '0;
                            n_state   = S_SCAN;
                        end
                        default: begin
                            n_pstat = ST_OK;
                        end
                    endcase
                end
            end

            S_ACCESS: begin
                n_pdata = rd_wide[DATA_W-1:0];
                n_state = S_DONE;
            end

            // zero-fill from the count up to the index, then store the word
            S_FILL: begin
                mem_we = 1'b1;
                if (CMP_W'(r_count) < CMP_W'(r_idx)) begin
                    mem_waddr = r_count[ADDR_W-1:0];
                    mem_wdata = '0;
                    n_count   = r_count + 1'b1;
                end else begin
                    mem_waddr = r_idx[ADDR_W-1:0];
                    mem_wdata = r_val;
                    if (CMP_W'(r_count) <= CMP_W'(r_idx)) begin
                        n_count = CNT_W'(r_idx) + 1'b1;
                    end
                    n_state = S_DONE;
                end
            end

            // read data holds entry r_ptr; it moves down one place
            S_SHIFT: begin
                if (r_ptr < r_count) begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(r_ptr - 1'b1);
                    mem_wdata = mem_rdata;
                    n_ptr     = r_ptr + 1'b1;
                    mem_raddr = n_ptr[ADDR_W-1:0];
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end

            S_SCAN: begin
                if (r_ptr >= r_count) begin
                    n_state = S_DONE;
                end else if (mem_rdata == r_val) begin
                    n_pfound = 1'b1;
                    n_ppos   = r_ptr[ADDR_W-1:0];
                    if (r_func == FN_REMOVE) begin
                        n_ptr     = r_ptr + 1'b1;
                        mem_raddr = n_ptr[ADDR_W-1:0];
                        n_state   = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_ptr     = r_ptr + 1'b1;
                    mem_raddr = n_ptr[ADDR_W-1:0];
                end
            end

            // hand the result to the output register once the slot is free
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_pstat;
                    n_odata  = r_pdata;
                    n_ofound = r_pfound;
                    n_opos   = POS_W'(r_ppos);
                    n_ocount = COUNT_OUT_W'(r_count);
                    n_oempty = (r_count == '0);
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.status    = r_ostat;
    assign o_rsp.data_out  = r_odata;
    assign o_rsp.found     = r_ofound;
    assign o_rsp.position  = r_opos;
    assign o_rsp.count     = r_ocount;
    assign o_rsp.empty_res = r_oempty;

endmodule

@@ dv/tb_bounded_int_vector_engine_core.sv @@
// ----------------------------------------------------------------------------
// tb_bounded_int_vector_engine_core
// Self-checking bench for the bounded vector engine. A class keeps its own
// copy of the store and the used count, predicts one result per accepted
// request and checks every result transfer field by field, in order.
// Directed requests cover the error codes, the first-match rule, zero-fill
// and the full-capacity corners. Random requests keep the vector short.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_bounded_int_vector_engine_core;
    import bive_pkg::*;

    typedef struct packed {
        t_status                 status;
        logic [DATA_W-1:0]       data_out;
        logic                    found;
        logic [POS_W-1:0]        position;
        logic [COUNT_OUT_W-1:0]  count;
        logic                    empty_res;
    } t_vec_result;

    class vector_scoreboard;
        localparam int CAP = DEF_CAPACITY;

        logic [DATA_W-1:0] words [CAP];
        int unsigned       used;
        t_vec_result       expected [$];
        int                errors;
        int                seen;

        function new();
            used   = 0;
            errors = 0;
            seen   = 0;
        endfunction

        // shift the entries above the given slot down by one and shrink the used count
        function void erase_entry(int unsigned at);
            for (int unsigned i = at; i + 1 < used; i++) begin
                words[i] = words[i + 1];
            end
            used--;
        endfunction

        function void note_request(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                                   logic [DATA_W-1:0] val);
            t_vec_result r;
            r = '0;
            r.status = ST_OK;
            case (fn)
                FN_PUSH: begin
                    if (used >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        words[used] = val;
                        used++;
                    end
                end
                FN_POP: begin
                    if (used == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.data_out = words[used - 1];
                        used--;
                    end
                end
                FN_READ: begin
                    if (idx >= used) r.status = ST_RANGE;
                    else r.data_out = words[idx];
                end
                FN_WRITE: begin
                    if (idx >= CAP) begin
                        r.status = ST_RANGE;
                    end else begin
                        while (used < idx) begin
                            words[used] = '0;
                            used++;
                        end
                        words[idx] = val;
                        if (used <= idx) used = idx + 1;
                    end
                end
                FN_ERASE: begin
                    if (idx >= used) r.status = ST_RANGE;
                    else erase_entry(32'(idx));
                end
                FN_FIND, FN_REMOVE: begin
                    for (int unsigned i = 0; i < used; i++) begin
                        if (!r.found && words[i] == val) begin
                            r.found    = 1'b1;
                            r.position = i[POS_W-1:0];
                        end
                    end
                    if (fn == FN_REMOVE && r.found) erase_entry(32'(r.position));
                end
                default: ;
            endcase
            r.count     = used[COUNT_OUT_W-1:0];
            r.empty_res = (used == 0);
            expected.push_back(r);
        endfunction

        task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            errors++;
            $display("mismatch on result %0d: %s got %0h expected %0h", seen, what, got, want);
        endtask

        task check_result(t_vec_result got);
            t_vec_result want;
            seen++;
            if (expected.size() == 0) begin
                report_mismatch("unexpected transfer, status", DATA_W'(got.status), '0);
            end else begin
                want = expected.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
                if (got.data_out != want.data_out)
                    report_mismatch("data_out", got.data_out, want.data_out);
                if (got.found != want.found)
                    report_mismatch("found", DATA_W'(got.found), DATA_W'(want.found));
                if (got.position != want.position)
                    report_mismatch("position", DATA_W'(got.position),
                                    DATA_W'(want.position));
                if (got.count != want.count)
                    report_mismatch("count", DATA_W'(got.count), DATA_W'(want.count));
                if (got.empty_res != want.empty_res)
                    report_mismatch("empty_res", DATA_W'(got.empty_res),
                                    DATA_W'(want.empty_res));
            end
        endtask
    endclass

    localparam int          CAP          = DEF_CAPACITY;
    localparam int          RANDOM_ITEMS = 1870;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          SIZE_CEILING = 48;
    localparam logic [FUNC_W-1:0] FN_NOP = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bive_req_if req_if ();
    bive_rsp_if rsp_if ();

    bounded_int_vector_engine_core #(
        .CAPACITY   (CAP),
        .WORD_WIDTH (DEF_WORD_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    vector_scoreboard sb;
    t_vec_result      rsp_seen;
    int               burst_left  = 0;
    int               ready_mode  = 0;
    int               mode_left   = 0;
    int               stall_phase = 0;
    int               cycle_count = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: pick a stall style for a while, then switch
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(40, 300);
        end else begin
            mode_left--;
        end
        stall_phase = (stall_phase + 1) % 13;
        case (ready_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= (stall_phase >= 9);
            default: rsp_if.ready <= (stall_phase % 2 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_seen.status    = t_status'(rsp_if.status);
            rsp_seen.data_out  = rsp_if.data_out;
            rsp_seen.found     = rsp_if.found;
            rsp_seen.position  = rsp_if.position;
            rsp_seen.count     = rsp_if.count;
            rsp_seen.empty_res = rsp_if.empty_res;
            sb.check_result(rsp_seen);
        end
    end

    task automatic send(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                        input logic [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.func  <= fn;
        req_if.index <= idx;
        req_if.value <= val;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        sb.note_request(fn, idx, val);
    endtask

    // often values already stored so find and remove hit, plus random values, small values and extremes
    function automatic logic [DATA_W-1:0] pick_value(int unsigned n);
        int r;
        r = $urandom_range(0, 11);
        if (r <= 3) return $urandom;
        if (r <= 5) return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : 32'hFFFF_FFFF;
        if (r == 6) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0;
            endcase
        end
        if (n == 0) return $urandom;
        return sb.words[$urandom_range(0, n - 1)];
    endfunction

    task automatic send_random_request();
        int unsigned       n;
        int                pick;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
        n    = sb.used;
        pick = $urandom_range(0, 99);
        val  = pick_value(n);
        // index: mostly live entries, sometimes just past the end, sometimes far out
        case ($urandom_range(0, 9))
            0, 1:    idx = IDX_W'(n + $urandom_range(0, 3));
            2:       idx = IDX_W'($urandom_range(CAP, 65535));
            default: idx = (n == 0) ? IDX_W'($urandom_range(0, 3))
                                    : IDX_W'($urandom_range(0, n - 1));
        endcase
        if (pick < 22) begin
            if (n >= SIZE_CEILING) send(FN_POP, idx, val);
            else send(FN_PUSH, idx, val);
        end else if (pick < 34) begin
            send(FN_POP, idx, val);
        end else if (pick < 48) begin
            send(FN_READ, idx, val);
        end else if (pick < 60) begin
            if (n >= SIZE_CEILING) send(FN_ERASE, idx, val);
            else if (idx < CAP) send(FN_WRITE, IDX_W'(idx % (n + 8)), val);
            else send(FN_WRITE, idx, val);
        end else if (pick < 70) begin
            send(FN_ERASE, idx, val);
        end else if (pick < 82) begin
            send(FN_FIND, idx, val);
        end else if (pick < 94) begin
            send(FN_REMOVE, idx, val);
        end else if (pick < 97) begin
            send(FN_NOP, idx, val);
        end else begin
            send(FN_POP, idx, val);
        end
    endtask

    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.func  = FN_PUSH;
        req_if.index = '0;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // error codes and misses on an empty vector, plus an unused code
        send(FN_POP,    16'd0, 32'h0);
        send(FN_READ,   16'd0, 32'h0);
        send(FN_ERASE,  16'd0, 32'h0);
        send(FN_FIND,   16'd0, 32'h0);
        send(FN_REMOVE, 16'd0, 32'h5);
        send(FN_NOP,    16'hFFFF, 32'hFFFF_FFFF);
        // duplicates: find and remove take the first match
        send(FN_PUSH,   16'd0, 32'h7FFF_FFFF);
        send(FN_PUSH,   16'd0, 32'h8000_0000);
        send(FN_PUSH,   16'd0, 32'hFFFF_FFFF);
        send(FN_PUSH,   16'd0, 32'h8000_0000);
        send(FN_FIND,   16'd0, 32'h8000_0000);
        send(FN_REMOVE, 16'd0, 32'h8000_0000);
        send(FN_READ,   16'd2, 32'h0);
        send(FN_READ,   16'd3, 32'h0);
        // write past the end zero-fills the gap
        send(FN_WRITE,  16'd6, 32'h1234_5678);
        send(FN_FIND,   16'd0, 32'h0);
        send(FN_ERASE,  16'd0, 32'h0);
        send(FN_ERASE,  16'd5, 32'h0);
        send(FN_WRITE,  16'(CAP), 32'hDEAD_BEEF);
        send(FN_WRITE,  16'hFFFF, 32'hDEAD_BEEF);
        send(FN_READ,   16'hFFFF, 32'h0);
        send(FN_WRITE,  16'd1, 32'hA5A5_5A5A);
        send(FN_POP,    16'd0, 32'h0);
        send(FN_NOP,    16'd0, 32'h0);

        repeat (RANDOM_ITEMS) send_random_request();

        // capacity corners: fill to the top, longest scans and shifts
        send(FN_WRITE,  16'(CAP - 1), 32'h1357_2468);
        send(FN_PUSH,   16'd0, 32'h0BAD_F00D);
        send(FN_FIND,   16'd0, 32'h1357_2468);
        send(FN_READ,   16'(CAP - 1), 32'h0);
        send(FN_WRITE,  16'(CAP), 32'h0);
        send(FN_ERASE,  16'd0, 32'h0);
        send(FN_FIND,   16'd0, 32'h2468_ACE1);
        send(FN_PUSH,   16'd0, 32'h8000_0001);
        send(FN_REMOVE, 16'd0, 32'h8000_0001);
        send(FN_POP,    16'd0, 32'h0);
        send(FN_READ,   16'(CAP - 1), 32'h0);
        @(negedge i_clk);
        req_if.valid <= 1'b0;

        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ bounded_int_vector_engine_core.f @@
hdl/bive_pkg.sv
hdl/bive_req_if.sv
hdl/bive_rsp_if.sv
hdl/bive_ram.sv
hdl/bounded_int_vector_engine_core.sv
dv/tb_bounded_int_vector_engine_core.sv
